@@ hdl/rcf_pkg.sv @@
// Package for the record chunk framer: shared constants, the command
// record passed from the front end to the back end, and the CRC-16 byte update.
// No dependencies.
package rcf_pkg;

    // Default sizing of the framer.
    localparam int DEF_RECORD_BYTES = 32;
    localparam int DEF_MAX_PAYLOAD  = 512;
    localparam int CMDQ_DEPTH       = 2;

    // Fixed field widths.
    localparam int MTU_W  = 10;
    localparam int LEN_W  = 11;
    localparam int LEFT_W = 10;
    localparam int SEQ_W  = 16;
    localparam int CRC_W  = 16;

    localparam logic [MTU_W-1:0] MTU_MIN      = MTU_W'(23);
    localparam logic [MTU_W-1:0] MTU_OVERHEAD = MTU_W'(9);
    localparam logic [CRC_W-1:0] CRC_INIT     = 16'hFFFF;
    localparam logic [CRC_W-1:0] CRC_POLY     = 16'h1021;

    // Status codes of a result transaction.
    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_MTU_SMALL = 1'b1;

    // One accepted input byte, already classified by the front end.
    typedef struct packed {
        logic             err;
        logic             open;
        logic             close;
        logic [SEQ_W-1:0] seq;
        logic [LEN_W-1:0] len;
        logic [7:0]       data;
    } cmd_t;

    // One byte through CRC-16/CCITT-FALSE, MSB first.
    function automatic logic [CRC_W-1:0] crc16_byte(input logic [CRC_W-1:0] crc_in,
                                                    input logic [7:0] b);
        logic [CRC_W-1:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if (c[CRC_W-1])
            begin
                c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[CRC_W-2:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

@@ hdl/rcf_cmd_queue.sv @@
// Short command queue between the framer front end and back end.
// Depends on rcf_pkg for the command record type.
module rcf_cmd_queue
    import rcf_pkg::*;
#(
    parameter int DEPTH = CMDQ_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  cmd_t wr_cmd,
    input  logic rd_en,
    output cmd_t rd_cmd,
    output logic q_full,
    output logic q_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    cmd_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign q_full  = (count_reg == CNT_FULL);
    assign q_empty = (count_reg == '0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_cmd  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule

@@ hdl/rcf_front.sv @@
// Front end of the framer: MTU register, chunk limit pipeline, chunk
// bookkeeping and classification of each accepted byte. Depends on rcf_pkg.
module rcf_front
    import rcf_pkg::*;
#(
    parameter int RECORD_BYTES = DEF_RECORD_BYTES,
    parameter int MAX_PAYLOAD  = DEF_MAX_PAYLOAD
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [MTU_W-1:0] att_mtu,
    input  logic             push,
    output logic             full,
    input  logic [7:0]       data_byte,
    input  logic [15:0]      bytes_left,
    input  logic             cmd_full,
    output logic             cmd_push,
    output cmd_t             cmd
);

    // Division by the record size is a multiply by a rounded-up reciprocal.
    localparam int RECIP_SHIFT = 20;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int QPROD_W     = MTU_W + RECIP_W;
    localparam int RB_W        = $clog2(RECORD_BYTES + 1);
    localparam int PPROD_W     = MTU_W + RB_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'((2 ** RECIP_SHIFT + RECORD_BYTES - 1) / RECORD_BYTES);
    localparam logic [PPROD_W-1:0] RB_MULT = PPROD_W'(RECORD_BYTES);
    localparam logic [PPROD_W-1:0] PAY_CAP = PPROD_W'(MAX_PAYLOAD);

    logic [MTU_W-1:0]   mtu_reg;
    logic [1:0]         settle_reg;
    logic [MTU_W-1:0]   quot_reg, quot_next;
    logic [LEN_W-1:0]   limit_reg, limit_next;
    logic [LEFT_W-1:0]  chunk_left_reg, chunk_left_next;
    logic [SEQ_W-1:0]   seq_reg, seq_next;

    logic [MTU_W-1:0]   eff_mtu;
    logic [MTU_W-1:0]   budget;
    logic [QPROD_W-1:0] quot_prod;
    logic [PPROD_W-1:0] limit_prod;
    logic               accept;
    logic               opening;
    logic               is_err;
    logic               is_close;
    logic [15:0]        left_eff;
    logic [LEN_W-1:0]   open_len;

    assign cfg_ready = 1'b1;
    assign full      = cmd_full || (settle_reg != 2'd0);
    assign accept    = push && !full;

    // Limit pipeline: floor(budget / RECORD_BYTES), then times RECORD_BYTES, capped.
    always_comb
    begin
        eff_mtu    = (mtu_reg < MTU_MIN) ? MTU_MIN : mtu_reg;
        budget     = eff_mtu - MTU_OVERHEAD;
        quot_prod  = QPROD_W'(budget) * QPROD_W'(RECIP);
        quot_next  = quot_prod[RECIP_SHIFT +: MTU_W];
        limit_prod = PPROD_W'(quot_reg) * RB_MULT;
        limit_next = (limit_prod > PAY_CAP) ? LEN_W'(PAY_CAP) : LEN_W'(limit_prod);
    end

    // Classification of the byte on the input ports.
    always_comb
    begin
        opening  = (chunk_left_reg == '0);
        left_eff = (bytes_left == 16'd0) ? 16'd1 : bytes_left;
        open_len = (left_eff < 16'(limit_reg)) ? LEN_W'(left_eff) : limit_reg;
        is_err   = opening && (limit_reg == '0);
        is_close = opening ? (open_len == LEN_W'(1)) : (chunk_left_reg == LEFT_W'(1));

        cmd.err   = is_err;
        cmd.open  = opening && !is_err;
        cmd.close = is_close && !is_err;
        cmd.seq   = seq_reg;
        cmd.len   = open_len;
        cmd.data  = data_byte;
        cmd_push  = accept;

        chunk_left_next = chunk_left_reg;
        seq_next        = seq_reg;
        if (accept && !is_err)
        begin
            if (opening)
            begin
                chunk_left_next = LEFT_W'(open_len - 1'b1);
            end
            else
            begin
                chunk_left_next = chunk_left_reg - 1'b1;
            end
            if (is_close)
            begin
                seq_next = seq_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mtu_reg        <= MTU_MIN;
            settle_reg     <= 2'd2;
            chunk_left_reg <= '0;
            seq_reg        <= '0;
        end
        else
        begin
            chunk_left_reg <= chunk_left_next;
            seq_reg        <= seq_next;
            if (cfg_valid && cfg_ready)
            begin
                mtu_reg    <= att_mtu;
                settle_reg <= 2'd2;
            end
            else if (settle_reg != 2'd0)
            begin
                settle_reg <= settle_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg  <= quot_next;
        limit_reg <= limit_next;
    end

endmodule

@@ hdl/rcf_back.sv @@
// Back end of the framer: walks each queued command through its header, data and CRC bytes
// or one error result into the output register, one per cycle while pop allows. Depends on rcf_pkg.
module rcf_back
    import rcf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cmd_t       head,
    input  logic       head_valid,
    output logic       head_pop,
    input  logic       pop,
    output logic       empty,
    output logic [7:0] out_byte,
    output logic       chunk_end,
    output logic       last_of_step,
    output logic       status
);

    typedef enum logic [2:0] {
        PH_ERR,
        PH_HDR0,
        PH_HDR1,
        PH_HDR2,
        PH_HDR3,
        PH_DATA,
        PH_CRC0,
        PH_CRC1
    } phase_t;

    phase_t           phase_reg, phase_next;
    phase_t           cur_phase;
    logic             busy_reg, busy_next;
    logic [CRC_W-1:0] crc_reg, crc_next;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       byte_reg, byte_next;
    logic             end_reg, end_next;
    logic             last_reg, last_next;
    logic             status_reg, status_next;

    logic             advance;
    logic             fire;
    logic [7:0]       cur_byte;
    logic             cur_last;
    logic             cur_crc_in;
    logic [CRC_W-1:0] crc_base;
    logic [15:0]      len16;

    assign empty        = !out_valid_reg;
    assign out_byte     = byte_reg;
    assign chunk_end    = end_reg;
    assign last_of_step = last_reg;
    assign status       = status_reg;

    assign advance  = !out_valid_reg || pop;
    assign fire     = advance && head_valid;
    assign head_pop = fire && cur_last;

    always_comb
    begin
        len16 = 16'(head.len);
        if (busy_reg)
        begin
            cur_phase = phase_reg;
        end
        else if (head.err)
        begin
            cur_phase = PH_ERR;
        end
        else if (head.open)
        begin
            cur_phase = PH_HDR0;
        end
        else
        begin
            cur_phase = PH_DATA;
        end

        cur_byte   = 8'h00;
        cur_last   = 1'b0;
        cur_crc_in = 1'b0;
        phase_next = phase_reg;
        case (cur_phase)
            PH_ERR:
            begin
                cur_last = 1'b1;
            end
            PH_HDR0:
            begin
                cur_byte   = head.seq[7:0];
                cur_crc_in = 1'b1;
                phase_next = PH_HDR1;
            end
            PH_HDR1:
            begin
                cur_byte   = head.seq[15:8];
                cur_crc_in = 1'b1;
                phase_next = PH_HDR2;
            end
            PH_HDR2:
            begin
                cur_byte   = len16[7:0];
                cur_crc_in = 1'b1;
                phase_next = PH_HDR3;
            end
            PH_HDR3:
            begin
                cur_byte   = len16[15:8];
                cur_crc_in = 1'b1;
                phase_next = PH_DATA;
            end
            PH_DATA:
            begin
                cur_byte   = head.data;
                cur_crc_in = 1'b1;
                cur_last   = !head.close;
                phase_next = PH_CRC0;
            end
            PH_CRC0:
            begin
                cur_byte   = crc_reg[7:0];
                phase_next = PH_CRC1;
            end
            PH_CRC1:
            begin
                cur_byte = crc_reg[15:8];
                cur_last = 1'b1;
            end
            default:
            begin
                cur_last = 1'b1;
            end
        endcase

        // A header starts a fresh CRC.
        crc_base = (cur_phase == PH_HDR0) ? CRC_INIT : crc_reg;
        crc_next = crc_reg;
        if (fire && cur_crc_in)
        begin
            crc_next = crc16_byte(crc_base, cur_byte);
        end

        busy_next      = busy_reg;
        out_valid_next = out_valid_reg;
        byte_next      = byte_reg;
        end_next       = end_reg;
        last_next      = last_reg;
        status_next    = status_reg;
        if (fire)
        begin
            busy_next      = !cur_last;
            out_valid_next = 1'b1;
            byte_next      = cur_byte;
            end_next       = (cur_phase == PH_CRC1);
            last_next      = cur_last;
            status_next    = (cur_phase == PH_ERR) ? STATUS_MTU_SMALL : STATUS_OK;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_DATA;
            busy_reg      <= 1'b0;
            crc_reg       <= CRC_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                phase_reg <= phase_next;
            end
            busy_reg      <= busy_next;
            crc_reg       <= crc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg   <= byte_next;
        end_reg    <= end_next;
        last_reg   <= last_next;
        status_reg <= status_next;
    end

endmodule

@@ hdl/record_chunk_framer_crc16.sv @@
// Record chunk framer with CRC-16/CCITT-FALSE. Each byte passes through the command queue and
// the output register before its results. Throughput: one byte per cycle inside a chunk while
// results are popped; an opening byte yields 5 results, a closing byte 3 and one that both opens
// and closes 7, spelled out by the one-byte-per-cycle back end. Reset (async, active low): MTU 23,
// sequence 0, no chunk open; full is held after reset and every MTU write while the limit is recomputed.
module record_chunk_framer_crc16
    import rcf_pkg::*;
#(
    parameter int RECORD_BYTES = DEF_RECORD_BYTES,
    parameter int MAX_PAYLOAD  = DEF_MAX_PAYLOAD,
    parameter int QUEUE_DEPTH  = CMDQ_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    // MTU write channel; always ready.
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [MTU_W-1:0] att_mtu,
    // Input queue side: a transaction happens when push is high and full is low.
    input  logic             push,
    output logic             full,
    input  logic [7:0]       data_byte,
    input  logic [15:0]      bytes_left,
    // Result queue side: a transaction happens when pop is high and empty is low.
    output logic             empty,
    input  logic             pop,
    output logic [7:0]       out_byte,
    output logic             chunk_end,
    output logic             last_of_step,
    output logic             status
);

    // The front end tracks how many bytes are left in the open chunk and the
    // sequence number, so it can classify every incoming byte in the cycle it
    // arrives: drop with an error, open a chunk, continue or close it. Each
    // classified byte becomes one command in a short queue. The back end pulls
    // commands and spells them out as header, data and CRC bytes, one per cycle while
    // results are popped, keeping the running CRC. The queue lets the front keep taking bytes while
    // the back end is busy with header or CRC bytes.
    cmd_t front_cmd;
    cmd_t head_cmd;
    logic front_push;
    logic q_full;
    logic q_empty;
    logic head_pop;

    rcf_front #(
        .RECORD_BYTES (RECORD_BYTES),
        .MAX_PAYLOAD  (MAX_PAYLOAD)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .att_mtu    (att_mtu),
        .push       (push),
        .full       (full),
        .data_byte  (data_byte),
        .bytes_left (bytes_left),
        .cmd_full   (q_full),
        .cmd_push   (front_push),
        .cmd        (front_cmd)
    );

    rcf_cmd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (front_push),
        .wr_cmd  (front_cmd),
        .rd_en   (head_pop),
        .rd_cmd  (head_cmd),
        .q_full  (q_full),
        .q_empty (q_empty)
    );

    // The back end owns the output register, which decouples the result side
    // from the queue; a waiting result blocks new input transactions only once the queue fills.
    rcf_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head_cmd),
        .head_valid   (!q_empty),
        .head_pop     (head_pop),
        .pop          (pop),
        .empty        (empty),
        .out_byte     (out_byte),
        .chunk_end    (chunk_end),
        .last_of_step (last_of_step),
        .status       (status)
    );

`ifndef SYNTHESIS
    // An error result stands alone: it closes its step and never ends a chunk.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && status == STATUS_MTU_SMALL) |-> (last_of_step && !chunk_end && out_byte == 8'h00))
    else $error("error result malformed");

    // The final CRC byte of a chunk is always the last result of its step.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && chunk_end) |-> last_of_step)
    else $error("chunk end not last of step");

    // After an MTU write the input side holds off while the limit is recomputed.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_valid && cfg_ready) |=> full)
    else $error("input accepted during limit update");
`endif

endmodule

@@ tb/sv/tb_record_chunk_framer_crc16.sv @@
// Self-checking testbench for record_chunk_framer_crc16: directed table then random messages.
// Depends on rcf_pkg (hdl/rcf_pkg.sv) and the framer RTL; needs no other files.
`timescale 1ns / 100ps

module tb_record_chunk_framer_crc16
    import rcf_pkg::*;
();

    localparam int CLK_PERIOD    = 4;
    localparam int RESET_CYCLES  = 11;
    localparam int RANDOM_ITEMS  = 400;
    localparam int BIG_CHUNK_MTU = 521;     // exactly 512 payload bytes per chunk
    localparam int BIG_MSG_LEN   = 600;     // longer than the payload cap
    localparam int BIG_SLICE     = 48;      // bytes of that message sent in one phase
    localparam int DRAIN_LIMIT   = 4000;    // cycles allowed for the result side to empty
    localparam int SETTLE_CYCLES = 4;       // settling time after the result side has emptied
    localparam int REPORT_LIMIT  = 10;
    localparam longint TIMEOUT_NS = 5_000_000;

    // One transaction on the result side.
    typedef struct packed {
        logic [7:0] data;
        logic       chunk_end;
        logic       last;
        logic       status;
    } framer_result_t;

    typedef enum logic {ROW_ITEM, ROW_MTU} row_kind_t;

    // One row of the directed table. For ROW_MTU, value carries the MTU; for ROW_ITEM it
    // carries the data byte. Rows with typed set carry their result in known, the rest are
    // checked against the predictor.
    typedef struct packed {
        row_kind_t      kind;
        logic [15:0]    value;
        logic [15:0]    left;
        logic           typed;
        framer_result_t known;
    } stim_row_t;

    localparam framer_result_t PREDICTED = '0;
    localparam framer_result_t MTU_SMALL_RESULT = '{8'h00, 1'b0, 1'b1, STATUS_MTU_SMALL};

    localparam int DIRECTED_ROWS = 23;
    localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
        // The reset MTU of 23 leaves no room for one record, so every byte is refused.
        '{ROW_ITEM, 16'h00A5, 16'h0001, 1'b1, MTU_SMALL_RESULT},
        // An MTU below the legal range behaves as the minimum.
        '{ROW_MTU,  16'd22,   16'h0000, 1'b0, PREDICTED},
        '{ROW_ITEM, 16'h00FF, 16'hFFFF, 1'b1, MTU_SMALL_RESULT},
        // The largest MTU that still leaves the budget one byte short of a record.
        '{ROW_MTU,  16'd40,   16'h0000, 1'b0, PREDICTED},
        '{ROW_ITEM, 16'h0000, 16'h0000, 1'b1, MTU_SMALL_RESULT},
        // Smallest working MTU: 32-byte chunks.
        '{ROW_MTU,  16'd41,   16'h0000, 1'b0, PREDICTED},
        // Zero bytes left at chunk open counts as one: a chunk that opens and closes at once.
        '{ROW_ITEM, 16'h0000, 16'h0000, 1'b0, PREDICTED},
        '{ROW_ITEM, 16'h00FF, 16'h0001, 1'b0, PREDICTED},
        // A three-byte chunk whose middle byte claims a bogus length, which must be ignored.
        '{ROW_ITEM, 16'h0012, 16'h0003, 1'b0, PREDICTED},
        '{ROW_ITEM, 16'h0034, 16'hFFFF, 1'b0, PREDICTED},
        '{ROW_ITEM, 16'h0056, 16'h0001, 1'b0, PREDICTED},
        // Open a three-byte chunk, then drop the MTU below one record while it is open:
        // the chunk still runs to its end and only the next byte is refused.
        '{ROW_ITEM, 16'h0080, 16'h0003, 1'b0, PREDICTED},
        '{ROW_MTU,  16'd23,   16'h0000, 1'b0, PREDICTED},
        '{ROW_ITEM, 16'h007F, 16'h0000, 1'b0, PREDICTED},
        '{ROW_ITEM, 16'h0001, 16'h0000, 1'b0, PREDICTED},
        '{ROW_ITEM, 16'h0055, 16'h0005, 1'b1, MTU_SMALL_RESULT},
        // Top of the register: the payload cap of 512 applies.
        '{ROW_MTU,  16'h03FF, 16'h0000, 1'b0, PREDICTED},
        '{ROW_ITEM, 16'h00C3, 16'h0002, 1'b0, PREDICTED},
        '{ROW_ITEM, 16'h003C, 16'h0001, 1'b0, PREDICTED},
        '{ROW_MTU,  16'd0,    16'h0000, 1'b0, PREDICTED},
        '{ROW_ITEM, 16'h00AA, 16'h8000, 1'b1, MTU_SMALL_RESULT},
        // 64-byte chunks; the last row opens one that the random part carries on.
        '{ROW_MTU,  16'd73,   16'h0000, 1'b0, PREDICTED},
        '{ROW_ITEM, 16'h005A, 16'h00FF, 1'b0, PREDICTED}
    };

    // Ports of the block. Every input holds a known value from time zero.
    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [MTU_W-1:0] att_mtu = '0;
    logic             push = 1'b0;
    logic             full;
    logic [7:0]       data_byte = '0;
    logic [15:0]      bytes_left = '0;
    logic             empty;
    logic             pop = 1'b0;
    logic [7:0]       out_byte;
    logic             chunk_end;
    logic             last_of_step;
    logic             status;

    // Shadow copy of the framer state, advanced once per accepted input transaction.
    logic [MTU_W-1:0] mtu_now = MTU_MIN;
    logic [15:0]      seq_now = '0;
    logic [15:0]      crc_now = CRC_INIT;
    logic [9:0]       chunk_remaining = '0;

    // Bytes that the last input byte produces, and every byte still owed by the block.
    framer_result_t   step_results[$];
    framer_result_t   pending_results[$];

    int unsigned      failures = 0;
    int unsigned      items_sent = 0;
    int unsigned      send_idle_max = 15;
    int unsigned      recv_idle_max = 15;

    record_chunk_framer_crc16 dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .att_mtu      (att_mtu),
        .push         (push),
        .full         (full),
        .data_byte    (data_byte),
        .bytes_left   (bytes_left),
        .empty        (empty),
        .pop          (pop),
        .out_byte     (out_byte),
        .chunk_end    (chunk_end),
        .last_of_step (last_of_step),
        .status       (status)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // The run ends here if the block stops answering.
    initial
    begin
        #(TIMEOUT_NS);
        $display("FAIL");
        $finish;
    end

    task automatic report_failure(input string msg);
        failures++;
        if (failures <= REPORT_LIMIT)
        begin
            $display("mismatch at %0t: %s", $realtime, msg);
        end
    endtask

    // CRC-16/CCITT-FALSE, one message bit at a time, most significant bit first.
    function automatic logic [15:0] crc_ccitt_step(input logic [15:0] crc,
                                                   input logic [7:0] b);
        logic [15:0] c;
        logic        feedback;
        int          k;
        c = crc;
        for (k = 7; k >= 0; k--)
        begin
            feedback = c[15] ^ b[k];
            c = {c[14:0], 1'b0};
            if (feedback)
            begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

    // Largest whole number of records that fits the MTU budget, capped at the max payload.
    function automatic logic [10:0] payload_limit(input logic [MTU_W-1:0] mtu);
        int m;
        int per;
        m = (mtu < MTU_MIN) ? int'(MTU_MIN) : int'(mtu);
        per = ((m - int'(MTU_OVERHEAD)) / DEF_RECORD_BYTES) * DEF_RECORD_BYTES;
        if (per > DEF_MAX_PAYLOAD)
        begin
            per = DEF_MAX_PAYLOAD;
        end
        return per[10:0];
    endfunction

    // Adds one good stream byte to the step; the caller keeps the running CRC.
    function automatic void emit_stream_byte(input logic [7:0] b, input logic is_end);
        step_results.push_back('{b, is_end, 1'b0, STATUS_OK});
    endfunction

    // Works out the stream bytes that one accepted input byte produces and advances the
    // shadow state. A chunk opens when none is open: four header bytes, then the data.
    // When the chunk's last payload byte goes out, the CRC follows, low byte first.
    function automatic void frame_byte(input logic [7:0] d, input logic [15:0] left);
        logic [10:0]    per;
        logic [15:0]    n;
        logic [7:0]     hdr [4];
        framer_result_t tail;
        int             i;
        step_results.delete();
        if (chunk_remaining == 0)
        begin
            per = payload_limit(mtu_now);
            if (per == 0)
            begin
                // No room for a record: one refusal, state untouched.
                step_results.push_back(MTU_SMALL_RESULT);
                return;
            end
            n = (left == 0) ? 16'd1 : left;
            if (n > per)
            begin
                n = per;
            end
            hdr = '{seq_now[7:0], seq_now[15:8], n[7:0], n[15:8]};
            crc_now = CRC_INIT;
            for (i = 0; i < 4; i++)
            begin
                crc_now = crc_ccitt_step(crc_now, hdr[i]);
                emit_stream_byte(hdr[i], 1'b0);
            end
            chunk_remaining = n[9:0];
        end
        crc_now = crc_ccitt_step(crc_now, d);
        emit_stream_byte(d, 1'b0);
        chunk_remaining = chunk_remaining - 10'd1;
        if (chunk_remaining == 0)
        begin
            emit_stream_byte(crc_now[7:0], 1'b0);
            emit_stream_byte(crc_now[15:8], 1'b1);
            seq_now = seq_now + 16'd1;
            crc_now = CRC_INIT;
        end
        tail = step_results.pop_back();
        tail.last = 1'b1;
        step_results.push_back(tail);
    endfunction

    // Offers one byte on the input side after a random gap. The task is entered and left
    // at a falling edge; push stays high on exit so back-to-back bytes follow without a gap.
    // Rows with a typed result queue that result; all others queue the predicted bytes.
    task automatic send_item(input logic [7:0] d, input logic [15:0] left,
                             input logic typed, input framer_result_t known);
        int unsigned gap;
        gap = $urandom_range(send_idle_max, 0);
        if (gap != 0)
        begin
            push <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        push       <= 1'b1;
        data_byte  <= d;
        bytes_left <= left;
        do @(posedge clk); while (full);
        frame_byte(d, left);
        if (typed)
        begin
            pending_results.push_back(known);
        end
        else
        begin
            foreach (step_results[i])
            begin
                pending_results.push_back(step_results[i]);
            end
        end
        items_sent++;
        @(negedge clk);
    endtask

    // Stops sending and waits for every owed byte, then lets the block settle.
    task automatic drain_results();
        int unsigned waited;
        push <= 1'b0;
        waited = 0;
        while (pending_results.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(negedge clk);
            waited++;
        end
        if (pending_results.size() != 0)
        begin
            report_failure($sformatf("%0d result bytes never arrived",
                                     pending_results.size()));
            pending_results.delete();
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // MTU writes happen only with the block idle.
    task automatic write_mtu(input logic [MTU_W-1:0] value);
        drain_results();
        cfg_valid <= 1'b1;
        att_mtu   <= value;
        do @(posedge clk); while (!cfg_ready);
        mtu_now = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // A well-formed message: bytes_left counts down to one.
    task automatic send_message(input int unsigned len);
        int unsigned k;
        for (k = len; k >= 1; k--)
        begin
            send_item(8'($urandom), 16'(k), 1'b0, PREDICTED);
        end
    endtask

    // A stray byte with an arbitrary length claim.
    task automatic send_noise();
        logic [15:0] left;
        case ($urandom_range(0, 3))
            0:       left = 16'h0000;
            1:       left = 16'hFFFF;
            2:       left = 16'($urandom_range(1, 4));
            default: left = 16'($urandom);
        endcase
        send_item(8'($urandom), left, 1'b0, PREDICTED);
    endtask

    // Picks the MTU of one random phase; roughly one phase in ten refuses every byte.
    function automatic logic [MTU_W-1:0] pick_mtu();
        case ($urandom_range(0, 9))
            0:       return MTU_W'(41);
            1:       return MTU_W'(73);
            2:       return MTU_W'($urandom_range(41, 200));
            3:       return MTU_W'($urandom_range(0, 40));
            4:       return MTU_W'(1023);
            5:       return MTU_W'($urandom_range(0, 1023));
            6:       return MTU_W'(517);
            default: return MTU_W'($urandom_range(41, 110));
        endcase
    endfunction

    // Result side: pops with random stalls, checks every transaction field by field
    // against the oldest owed byte. Entered and left at a falling edge like the sender.
    initial
    begin : result_side
        framer_result_t got;
        framer_result_t want;
        int unsigned    stall;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            stall = $urandom_range(recv_idle_max, 0);
            if (stall != 0)
            begin
                pop <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            pop <= 1'b1;
            do @(posedge clk); while (empty);
            got = '{out_byte, chunk_end, last_of_step, status};
            if (pending_results.size() == 0)
            begin
                report_failure($sformatf("unexpected result byte %02h end %0b last %0b st %0b",
                                         got.data, got.chunk_end, got.last, got.status));
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.data !== want.data || got.chunk_end !== want.chunk_end ||
                    got.last !== want.last || got.status !== want.status)
                begin
                    report_failure($sformatf(
                        "expected byte %02h end %0b last %0b st %0b, got %02h %0b %0b %0b",
                        want.data, want.chunk_end, want.last, want.status,
                        got.data, got.chunk_end, got.last, got.status));
                end
            end
            @(negedge clk);
        end
    end

    // Stimulus: reset, directed table, random phases, then the verdict.
    initial
    begin : stimulus
        int unsigned phase;
        int unsigned random_items;
        int unsigned phase_goal;
        int unsigned phase_start;
        int unsigned len;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // The directed rows run with idling on both sides.
        foreach (DIRECTED[i])
        begin
            if (DIRECTED[i].kind == ROW_MTU)
            begin
                write_mtu(DIRECTED[i].value[MTU_W-1:0]);
            end
            else
            begin
                send_item(DIRECTED[i].value[7:0], DIRECTED[i].left,
                          DIRECTED[i].typed, DIRECTED[i].known);
            end
        end

        // Random phases. Each one writes a fresh MTU (often with a chunk still open) and
        // picks whether each side idles. Phase 2 sends the head of a message longer than
        // the payload cap, back to back.
        random_items = 0;
        for (phase = 0; random_items < RANDOM_ITEMS; phase++)
        begin
            send_idle_max = ($urandom_range(0, 3) == 0) ? 0 : 15;
            recv_idle_max = ($urandom_range(0, 3) == 0) ? 0 : 15;
            if (phase == 2)
            begin
                write_mtu(MTU_W'(BIG_CHUNK_MTU));
                send_idle_max = 0;
                phase_start = items_sent;
                for (len = BIG_MSG_LEN; len > BIG_MSG_LEN - BIG_SLICE; len--)
                begin
                    send_item(8'($urandom), 16'(len), 1'b0, PREDICTED);
                end
                random_items += items_sent - phase_start;
            end
            else
            begin
                write_mtu(pick_mtu());
                phase_goal  = $urandom_range(25, 50);
                phase_start = items_sent;
                while (items_sent - phase_start < phase_goal)
                begin
                    // Now and then the sender holds off until the result side is empty.
                    if ($urandom_range(0, 29) == 0)
                    begin
                        drain_results();
                    end
                    if ($urandom_range(0, 3) == 0)
                    begin
                        send_noise();
                    end
                    else
                    begin
                        case ($urandom_range(0, 9))
                            0, 1, 2, 3, 4, 5: len = $urandom_range(1, 8);
                            6, 7, 8:          len = $urandom_range(9, 70);
                            default:          len = $urandom_range(71, 140);
                        endcase
                        send_message(len);
                    end
                end
                random_items += items_sent - phase_start;
            end
        end

        drain_results();
        if (failures == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

@@ record_chunk_framer_crc16.f @@
hdl/rcf_pkg.sv
hdl/rcf_cmd_queue.sv
hdl/rcf_front.sv
hdl/rcf_back.sv
hdl/record_chunk_framer_crc16.sv
tb/sv/tb_record_chunk_framer_crc16.sv
